// ===== design/ckx_pkg.sv =====
// ----------------------------------------------------------------------------
// ckx_pkg
// Shared types, codes and helpers for the CIGAR-guided k-mer extractor.
// ----------------------------------------------------------------------------
package ckx_pkg;

  localparam int unsigned OpcodeW = 2;
  localparam int unsigned PosW    = 31;
  localparam int unsigned CopW    = 4;
  localparam int unsigned LenW    = 28;
  localparam int unsigned CharW   = 8;
  localparam int unsigned HashW   = 30;
  localparam int unsigned KW      = 4;

  localparam logic [KW-1:0] KmerLengthReset = 4'd15;
  localparam logic [KW-1:0] RunCountMax     = 4'd15;

  // Item opcodes
  localparam logic [OpcodeW-1:0] OPC_START = 2'd0;
  localparam logic [OpcodeW-1:0] OPC_CIGAR = 2'd1;
  localparam logic [OpcodeW-1:0] OPC_BASE  = 2'd2;

  // BAM CIGAR op codes
  localparam logic [CopW-1:0] CIG_MATCH     = 4'd0;
  localparam logic [CopW-1:0] CIG_INS       = 4'd1;
  localparam logic [CopW-1:0] CIG_DEL       = 4'd2;
  localparam logic [CopW-1:0] CIG_REF_SKIP  = 4'd3;
  localparam logic [CopW-1:0] CIG_SOFT_CLIP = 4'd4;
  localparam logic [CopW-1:0] CIG_HARD_CLIP = 4'd5;
  localparam logic [CopW-1:0] CIG_EQUAL     = 4'd7;
  localparam logic [CopW-1:0] CIG_DIFF      = 4'd8;

  // Result status codes
  localparam logic STATUS_KMER  = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  // ASCII bases
  localparam logic [CharW-1:0] CHAR_A = 8'h41;
  localparam logic [CharW-1:0] CHAR_C = 8'h43;
  localparam logic [CharW-1:0] CHAR_G = 8'h47;
  localparam logic [CharW-1:0] CHAR_T = 8'h54;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [PosW-1:0]    start_pos;
    logic [CopW-1:0]    cigar_op;
    logic [LenW-1:0]    cigar_len;
    logic [CharW-1:0]   base_char;
  } item_t;

  typedef struct packed {
    logic             status;
    logic [HashW-1:0] kmer_hash;
    logic [PosW-1:0]  kmer_end_pos;
  } result_t;

  // Low 2k bits set, clipped to the hash width
  function automatic logic [HashW-1:0] kmer_mask(input logic [KW-1:0] k);
    logic [HashW-1:0] m;
    logic [KW:0]      k2;
    k2 = {k, 1'b0};
    for (int i = 0; i < HashW; i++) begin
      m[i] = ((KW+1)'(i) < k2);
    end
    return m;
  endfunction

  function automatic logic is_acgt(input logic [CharW-1:0] ch);
    return (ch == CHAR_A) || (ch == CHAR_C) || (ch == CHAR_G) || (ch == CHAR_T);
  endfunction

  // A=0 C=1 G=2 T=3; don't care for other characters
  function automatic logic [1:0] base_code(input logic [CharW-1:0] ch);
    logic [1:0] c;
    c = 2'd0;
    if (ch == CHAR_C) c = 2'd1;
    if (ch == CHAR_G) c = 2'd2;
    if (ch == CHAR_T) c = 2'd3;
    return c;
  endfunction

endpackage

// ===== design/ckx_channels.sv =====
// ----------------------------------------------------------------------------
// ckx channels
// Valid/ready channel interfaces for input items and results.
// ----------------------------------------------------------------------------
interface ckx_item_if
  import ckx_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [OpcodeW-1:0]  opcode;
  logic [PosW-1:0]     start_pos;
  logic [CopW-1:0]     cigar_op;
  logic [LenW-1:0]     cigar_len;
  logic [CharW-1:0]    base_char;

  modport source (output valid, output opcode, output start_pos, output cigar_op,
                  output cigar_len, output base_char, input ready);
  modport sink   (input valid, input opcode, input start_pos, input cigar_op,
                  input cigar_len, input base_char, output ready);
endinterface

interface ckx_result_if
  import ckx_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic             status;
  logic [HashW-1:0] kmer_hash;
  logic [PosW-1:0]  kmer_end_pos;

  modport source (output valid, output status, output kmer_hash, output kmer_end_pos,
                  input ready);
  modport sink   (input valid, input status, input kmer_hash, input kmer_end_pos,
                  output ready);
endinterface

// ===== design/ckx_core.sv =====
// ----------------------------------------------------------------------------
// ckx_core
// Alignment state registers and the combinational update applied per accepted item.
// ----------------------------------------------------------------------------
module ckx_core
  import ckx_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [KW-1:0] cfg_wdata,
  input  logic          fire,
  input  item_t         item,
  output logic          res_valid,
  output result_t       res
);

  logic [KW-1:0]    kmer_length;
  logic [HashW-1:0] rolling_hash, rolling_hash_next;
  logic [KW-1:0]    run_count, run_count_next;
  logic [PosW-1:0]  ref_position, ref_position_next;
  logic [CopW-1:0]  current_op, current_op_next;
  logic [LenW-1:0]  remaining_len, remaining_len_next;

  logic advances, consumes;

  assign advances = (current_op == CIG_MATCH) || (current_op == CIG_EQUAL) ||
                    (current_op == CIG_DIFF);
  assign consumes = advances || (current_op == CIG_INS);

  always_comb begin
    rolling_hash_next  = rolling_hash;
    run_count_next     = run_count;
    ref_position_next  = ref_position;
    current_op_next    = current_op;
    remaining_len_next = remaining_len;
    res_valid          = 1'b0;
    res                = '0;
    unique case (item.opcode)
      OPC_START: begin
        ref_position_next  = item.start_pos;
        rolling_hash_next  = '0;
        run_count_next     = '0;
        current_op_next    = '0;
        remaining_len_next = '0;
      end
      OPC_CIGAR: begin
        if (remaining_len != '0) begin
          // entry arrived before the previous one was used up
          res_valid  = 1'b1;
          res.status = STATUS_ERROR;
        end else if (item.cigar_op == CIG_DEL || item.cigar_op == CIG_REF_SKIP) begin
          ref_position_next = ref_position + PosW'(item.cigar_len);
        end else if (item.cigar_op == CIG_SOFT_CLIP) begin
          run_count_next = '0;
        end else if (item.cigar_len == '0 || item.cigar_op == CIG_HARD_CLIP) begin
          // nothing to do
        end else begin
          current_op_next    = item.cigar_op;
          remaining_len_next = item.cigar_len;
        end
      end
      OPC_BASE: begin
        if (remaining_len == '0 || !consumes) begin
          res_valid  = 1'b1;
          res.status = STATUS_ERROR;
        end else begin
          if (is_acgt(item.base_char)) begin
            rolling_hash_next = {rolling_hash[HashW-3:0], base_code(item.base_char)}
                                & kmer_mask(kmer_length);
          end
          if (run_count < RunCountMax) begin
            run_count_next = run_count + KW'(1);
          end
          if (run_count_next >= kmer_length) begin
            res_valid        = 1'b1;
            res.status       = STATUS_KMER;
            res.kmer_hash    = rolling_hash_next;
            res.kmer_end_pos = ref_position + PosW'(1);
          end
          remaining_len_next = remaining_len - LenW'(1);
          if (advances) begin
            ref_position_next = ref_position + PosW'(1);
          end
        end
      end
      default: begin
        // unused opcode: ignored
      end
    endcase
    if (!fire) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length   <= KmerLengthReset;
      rolling_hash  <= '0;
      run_count     <= '0;
      ref_position  <= '0;
      current_op    <= '0;
      remaining_len <= '0;
    end else begin
      if (cfg_we) begin
        kmer_length <= cfg_wdata;
      end
      if (fire) begin
        rolling_hash  <= rolling_hash_next;
        run_count     <= run_count_next;
        ref_position  <= ref_position_next;
        current_op    <= current_op_next;
        remaining_len <= remaining_len_next;
      end
    end
  end

endmodule

// ===== design/ckx_out_buf.sv =====
// ----------------------------------------------------------------------------
// ckx_out_buf
// Result register with a skid stage; ready toward the core is registered.
// ----------------------------------------------------------------------------
module ckx_out_buf
  import ckx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  result_t  in_data,
  output logic     in_ready,
  ckx_result_if.source result
);

  logic    main_valid, skid_valid;
  result_t main_data, skid_data;
  logic    taken;

  assign taken    = main_valid && result.ready;
  assign in_ready = !skid_valid;

  assign result.valid        = main_valid;
  assign result.status       = main_data.status;
  assign result.kmer_hash    = main_data.kmer_hash;
  assign result.kmer_end_pos = main_data.kmer_end_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (taken) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= in_valid;
      end
    end else if (in_valid) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (taken) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else begin
        main_data <= in_data;
      end
    end else if (in_valid) begin
      if (!main_valid) begin
        main_data <= in_data;
      end else begin
        skid_data <= in_data;
      end
    end
  end

endmodule

// ===== design/cigar_guided_kmer_extractor.sv =====
// ----------------------------------------------------------------------------
// cigar_guided_kmer_extractor
// Walks a read along its CIGAR and emits 2-bit packed k-mers with end position.
// ----------------------------------------------------------------------------
// Usage:
//   item   - valid/ready channel; one transaction is a start-read, a CIGAR
//            entry or a read base, chosen by opcode.
//   result - valid/ready channel; one transaction is either a k-mer (hash and
//            reference end position) or an error flag. Each item gives at most
//            one result.
//   cfg_we / cfg_wdata - write k (kmer_length); change it only while idle.
// Latency: with the output empty, a result is presented the cycle after its
//   item's transaction.
// Throughput: one item per cycle while item.ready is high; the whole update is one pass of logic
//   from the item port through the state registers into the result register.
// Stall: a two-deep output (result register plus skid stage) absorbs one more
//   result after the receiver stalls; item.ready then drops until the skid
//   entry moves into the result register. Nothing is lost or repeated.
// Reset (rst, synchronous): state cleared, k set to 15, output empty.
// ----------------------------------------------------------------------------
module cigar_guided_kmer_extractor
  import ckx_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [KW-1:0] cfg_wdata,
  ckx_item_if.sink      item,
  ckx_result_if.source  result
);

  item_t   item_data;
  logic    fire;
  logic    buf_ready;
  logic    res_valid;
  result_t res;

  // pack the channel payload for the core
  assign item_data.opcode    = item.opcode;
  assign item_data.start_pos = item.start_pos;
  assign item_data.cigar_op  = item.cigar_op;
  assign item_data.cigar_len = item.cigar_len;
  assign item_data.base_char = item.base_char;

  // ready depends only on the skid stage, never on the receiver directly
  assign item.ready = buf_ready;
  assign fire       = item.valid && buf_ready;

  ckx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item_data),
    .res_valid (res_valid),
    .res       (res)
  );

  ckx_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_data  (res),
    .in_ready (buf_ready),
    .result   (result)
  );

endmodule
